// ----- hdl/mvavg_pkg.sv -----
// Package for the moving average filter: sizes, controller states and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none
package mvavg_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int WIN_W       = 7;
  localparam int PTR_W       = $clog2(MAX_WINDOW);
  localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W       = SAMPLE_BITS + PTR_W;
  localparam int STEP_W      = $clog2(SUM_W);

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(8);

  localparam logic             CMD_SAMPLE = 1'b0;
  localparam logic             CMD_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic update;
    logic load;
    logic step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- hdl/moving_average_filter_core.sv -----
// Top level of the moving average filter: controller plus datapath.
// Depends on mvavg_pkg, mvavg_ctrl and mvavg_dp.
//
//   port group   direction  handshake          payload
//   in_          request    in_valid/in_stall   in_command, in_sample
//   out_         result     out_valid/out_stall out_average
//   cfg_         write      cfg_valid/cfg_ready cfg_window_length
//
// A sample request goes from accept to result through one update step, one
// divider load, 22 restoring divider steps (one quotient bit per cycle
// over the 22-bit running sum) and one output load. A clear goes straight
// to the output load. The next request is accepted in the cycle after the
// result loads, so a new request is taken only once the last one is done.
// Reset is synchronous; ring entries are tracked by per-entry valid bits, so
// reset and clear take effect at once. A stalled result waits in the output
// register while the next request is accepted.
`default_nettype none
module moving_average_filter_core import mvavg_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_command,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic      [SAMPLE_BITS-1:0] out_average,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [WIN_W-1:0]       cfg_window_length
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  mvavg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .status     (status)
  );

  mvavg_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write         (cfg_valid && cfg_ready),
    .cfg_window_length (cfg_window_length),
    .in_sample         (in_sample),
    .out_average       (out_average),
    .cmd               (cmd),
    .status            (status)
  );

endmodule
`default_nettype wire

// ----- hdl/mvavg_ctrl.sv -----
// Controller for the moving average filter: request sequencing and output
// register handshake. Depends on mvavg_pkg.
`default_nettype none
module mvavg_ctrl import mvavg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_command,
  output logic            out_valid,
  input  wire logic       out_stall,
  output dp_cmd_t         cmd,
  input  wire dp_status_t status
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          if (in_command == CMD_CLEAR) begin
            cmd.clear = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/mvavg_dp.sv -----
// Datapath for the moving average filter: window register, sample ring,
// running sum, fill count, restoring divider and output register.
// Depends on mvavg_pkg.
`default_nettype none
module mvavg_dp import mvavg_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_write,
  input  wire logic [WIN_W-1:0]       cfg_window_length,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  output logic      [SAMPLE_BITS-1:0] out_average,
  input  wire dp_cmd_t                cmd,
  output dp_status_t                  status
);

  localparam logic [SUM_W-1:0] POS_MAX = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [SUM_W-1:0] NEG_MAX = SUM_W'(1 << (SAMPLE_BITS - 1));

  logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]  ring_vld_r;
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic                   rd_vld_r;

  logic [WIN_W-1:0]       win_r;
  logic [PTR_W-1:0]       ptr_r, ptr_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0] sample_r;

  logic [CNT_W-1:0]       win_eff;
  logic [SAMPLE_BITS-1:0] old_s;
  logic [CNT_W:0]         ptr_inc;

  logic [CNT_W-1:0]       div_r;
  logic [CNT_W-1:0]       rem_r;
  logic [SUM_W-1:0]       quo_r;
  logic                   neg_r;
  logic [STEP_W-1:0]      step_r;
  logic [CNT_W:0]         rem_sh;
  logic                   ge;
  logic [SAMPLE_BITS-1:0] avg;

  always_comb begin
    if (win_r == '0) begin
      win_eff = CNT_W'(1);
    end else if (CNT_W'(win_r) > CNT_W'(MAX_WINDOW)) begin
      win_eff = CNT_W'(MAX_WINDOW);
    end else begin
      win_eff = CNT_W'(win_r);
    end
  end

  assign old_s   = rd_vld_r ? rd_data_r : '0;
  assign sum_nxt = sum_r - {{PTR_W{old_s[SAMPLE_BITS-1]}}, old_s}
                         + {{PTR_W{sample_r[SAMPLE_BITS-1]}}, sample_r};
  assign ptr_inc = {1'b0, CNT_W'(ptr_r)} + (CNT_W + 1)'(1);
  assign ptr_nxt = (ptr_inc >= {1'b0, win_eff}) ? '0 : ptr_inc[PTR_W-1:0];
  assign cnt_nxt = (cnt_r < win_eff) ? cnt_r + CNT_W'(1) : cnt_r;

  always_ff @(posedge clk) begin
    rd_data_r <= ring[ptr_r];
    rd_vld_r  <= ring_vld_r[ptr_r];
    if (cmd.update) begin
      ring[ptr_r] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= WINDOW_RESET;
      ring_vld_r <= '0;
      ptr_r      <= '0;
      cnt_r      <= '0;
      sum_r      <= '0;
    end else begin
      if (cfg_write) begin
        win_r <= cfg_window_length;
      end
      if (cmd.clear) begin
        ring_vld_r <= '0;
        ptr_r      <= '0;
        cnt_r      <= '0;
        sum_r      <= '0;
      end else if (cmd.update) begin
        ring_vld_r[ptr_r] <= 1'b1;
        ptr_r             <= ptr_nxt;
        cnt_r             <= cnt_nxt;
        sum_r             <= sum_nxt;
      end
    end
  end

  assign rem_sh = {rem_r, quo_r[SUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, div_r});
  assign status.div_last = (step_r == STEP_W'(SUM_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
    end
    if (cmd.clear) begin
      quo_r <= '0;
      neg_r <= 1'b0;
    end else if (cmd.load) begin
      div_r  <= cnt_r;
      rem_r  <= '0;
      step_r <= '0;
      neg_r  <= sum_r[SUM_W-1];
      quo_r  <= sum_r[SUM_W-1] ? (~sum_r + SUM_W'(1)) : sum_r;
    end else if (cmd.step) begin
      rem_r  <= ge ? CNT_W'(rem_sh - {1'b0, div_r}) : rem_sh[CNT_W-1:0];
      quo_r  <= {quo_r[SUM_W-2:0], ge};
      step_r <= step_r + STEP_W'(1);
    end
  end

  always_comb begin
    if (neg_r) begin
      avg = (quo_r > NEG_MAX) ? NEG_MAX[SAMPLE_BITS-1:0]
                              : (~quo_r[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1));
    end else begin
      avg = (quo_r > POS_MAX) ? POS_MAX[SAMPLE_BITS-1:0] : quo_r[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_average <= avg;
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/mvavg_average_checker.sv -----
// Checker for the moving average filter: watches the request, result and window
// write channels, predicts each average and compares it with the result seen.
// Depends on mvavg_pkg.
module mvavg_average_checker import mvavg_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_stall,
  input  wire logic                   in_command,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                   out_valid,
  input  wire logic                   out_stall,
  input  wire logic [SAMPLE_BITS-1:0] out_average,
  input  wire logic                   cfg_valid,
  input  wire logic                   cfg_ready,
  input  wire logic [WIN_W-1:0]       cfg_window_length,
  output int                          mismatch_count,
  output int                          averages_due
);

  logic signed [SAMPLE_BITS-1:0] history [MAX_WINDOW];
  logic [PTR_W-1:0]              slot;
  logic [CNT_W-1:0]              filled;
  longint                        total;
  logic [WIN_W-1:0]              window_reg;
  logic signed [SAMPLE_BITS-1:0] averages_expected [$];

  function automatic int unsigned window_span();
    if (window_reg == '0) return 1;
    if (window_reg > MAX_WINDOW) return MAX_WINDOW;
    return window_reg;
  endfunction

  task automatic forget_history();
    for (int i = 0; i < MAX_WINDOW; i++) history[i] = '0;
    slot = '0;
    filled = '0;
    total = 0;
  endtask

  task automatic predict_average(input logic cmd, input logic signed [SAMPLE_BITS-1:0] smp,
                                 output logic signed [SAMPLE_BITS-1:0] avg);
    int unsigned span;
    int unsigned next_slot;
    longint      quotient;
    longint      top_val;
    longint      bottom_val;
    span = window_span();
    top_val = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    bottom_val = -top_val - 1;
    if (cmd == CMD_CLEAR) begin
      forget_history();
      avg = '0;
      return;
    end
    total = total - history[slot] + smp;
    history[slot] = smp;
    next_slot = slot + 1;
    if (next_slot >= span) next_slot = 0;
    slot = PTR_W'(next_slot);
    if (filled < span) filled = filled + 1'b1;
    quotient = total / longint'(filled);
    if (quotient > top_val) quotient = top_val;
    if (quotient < bottom_val) quotient = bottom_val;
    avg = SAMPLE_BITS'(quotient);
  endtask

  always @(posedge clk) begin : watch
    logic signed [SAMPLE_BITS-1:0] want;
    logic signed [SAMPLE_BITS-1:0] got;
    if (!rst_n) begin
      forget_history();
      window_reg = WINDOW_RESET;
      averages_expected.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = out_average;
        if (averages_expected.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected average: expected none, got %0d", $time, got);
        end else begin
          want = averages_expected.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display("%0t: average mismatch: expected %0d, got %0d", $time, want, got);
          end
        end
      end
      if (cfg_valid && cfg_ready) window_reg = cfg_window_length;
      if (in_valid && !in_stall) begin
        predict_average(in_command, in_sample, want);
        averages_expected.push_back(want);
      end
    end
    averages_due = averages_expected.size();
  end

endmodule

// ----- tb/sv/moving_average_filter_core_test.sv -----
// Testbench top for moving_average_filter_core: clock, reset, request and
// window stimulus, receiver stalls and the verdict.
// Depends on mvavg_pkg, moving_average_filter_core and mvavg_average_checker.
module moving_average_filter_core_test;
  import mvavg_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 40;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_command = CMD_SAMPLE;
  logic [SAMPLE_BITS-1:0] in_sample = '0;
  logic                   out_stall = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [WIN_W-1:0]       cfg_window_length = WINDOW_RESET;
  wire                    in_stall;
  wire                    out_valid;
  wire  [SAMPLE_BITS-1:0] out_average;
  wire                    cfg_ready;

  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int requests_sent = 0;
  int clears_sent = 0;
  int windows_set = 0;
  int mismatch_count;
  int averages_due;

  moving_average_filter_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_average(out_average),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_window_length(cfg_window_length)
  );

  mvavg_average_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_average(out_average),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_window_length(cfg_window_length),
    .mismatch_count(mismatch_count), .averages_due(averages_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  task automatic send_request(input logic cmd, input logic [SAMPLE_BITS-1:0] smp);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      in_command = 1'($urandom);
      in_sample = SAMPLE_BITS'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_command = cmd;
    in_sample = smp;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
    requests_sent++;
    if (cmd == CMD_CLEAR) clears_sent++;
  endtask

  task automatic set_window(input logic [WIN_W-1:0] w);
    do @(negedge clk); while (averages_due != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_window_length = w;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    windows_set++;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return SAMPLE_BITS'($urandom_range(16) - 8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [WIN_W-1:0] pick_window();
    case ($urandom_range(5))
      0:       return WIN_W'(1);
      1:       return WIN_W'(MAX_WINDOW);
      2:       return '0;
      3:       return WIN_W'($urandom_range(127, MAX_WINDOW + 1));
      default: return WIN_W'($urandom_range(MAX_WINDOW, 1));
    endcase
  endfunction

  initial begin
    int idle_mix [4];
    int stall_mix [4];
    idle_mix = '{0, 87, 0, 37};
    stall_mix = '{0, 0, 87, 37};
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    send_request(CMD_SAMPLE, 16'h7FFF);
    send_request(CMD_SAMPLE, 16'h8000);
    send_request(CMD_SAMPLE, 16'hFFFF);
    send_request(CMD_SAMPLE, 16'h0001);
    send_request(CMD_SAMPLE, 16'h5555);
    send_request(CMD_SAMPLE, 16'hAAAA);
    send_request(CMD_CLEAR, 16'h1234);
    send_request(CMD_SAMPLE, 16'hFFFD);
    send_request(CMD_SAMPLE, 16'hFFFC);

    set_window(WIN_W'(MAX_WINDOW));
    send_request(CMD_CLEAR, '0);
    repeat (5) send_request(CMD_SAMPLE, 16'h7FFF);
    set_window(WIN_W'(2));
    send_request(CMD_SAMPLE, 16'h7FFF);

    set_window(WIN_W'(MAX_WINDOW));
    send_request(CMD_CLEAR, '0);
    repeat (3) send_request(CMD_SAMPLE, 16'h8000);
    set_window(WIN_W'(1));
    send_request(CMD_SAMPLE, 16'h8000);

    set_window('0);
    send_request(CMD_CLEAR, '0);
    send_request(CMD_SAMPLE, 16'h8000);
    set_window(WIN_W'(127));
    send_request(CMD_SAMPLE, 16'h0007);

    for (int phase = 0; phase < 4; phase++) begin
      for (int setting = 0; setting < 4; setting++) begin
        set_window(pick_window());
        idle_pct = idle_mix[phase];
        stall_pct = stall_mix[phase];
        if ($urandom_range(3) != 0) send_request(CMD_CLEAR, pick_sample());
        repeat (80) begin
          send_request(($urandom_range(24) == 0) ? CMD_CLEAR : CMD_SAMPLE, pick_sample());
        end
        idle_pct = 0;
        stall_pct = 0;
      end
    end

    do @(negedge clk); while (averages_due != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d requests (%0d clears) over %0d window writes,", requests_sent,
             clears_sent, windows_set);
    $display("under free-running, sender-idle, receiver-stall and mixed traffic.");
    if (mismatch_count == 0 && averages_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mvavg_pkg.sv
hdl/mvavg_ctrl.sv
hdl/mvavg_dp.sv
hdl/moving_average_filter_core.sv
tb/sv/mvavg_average_checker.sv
tb/sv/moving_average_filter_core_test.sv
